@@ hw/rtl/tcp_rr_pkg.sv @@
// ============================================================================
// tcp_rr_pkg
// Shared types, constants and a sequence-space helper for the receive
// reassembly tracker.
// ============================================================================
package tcp_rr_pkg;

  typedef logic [31:0] seq_t;

  // One held out-of-order interval: [lo, hi) in sequence space
  typedef struct packed {
    seq_t lo;
    seq_t hi;
  } span_t;

  localparam int unsigned RING_BYTES_DEF    = 65536;
  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  localparam logic [15:0] WIN_MAX  = 16'hFFFF;
  localparam logic [16:0] READ_SAT = 17'h10000;

  // a precedes b modulo 2^32
  function automatic logic seq_before(seq_t a, seq_t b);
    seq_t d;
    d = a - b;
    return d[31];
  endfunction

endpackage

@@ hw/rtl/tcp_receive_reassembly.sv @@
// ============================================================================
// tcp_receive_reassembly
// Receive-side sequence tracker for one connection: trims and clips
// segments, advances the next expected sequence, keeps a sorted table of
// out-of-order intervals in a synchronous memory and drains reads.
// ============================================================================
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  -------------------------
//  input     in_func in_seg_seq in_seg_len           transfer on start && !busy
//            in_read_count
//  result    out_next_expected ... out_range_dropped transfer on out_valid
//  config    cfg_wdata                               write on cfg_we
//
//  One item at a time. A read passes through the states PREP, READ, READ2,
//  FIN and OUT. A segment that stores data passes through PREP, WIN, CLIP,
//  OFS and WPOS, then walks every held interval; an out-of-order insert into
//  a non-empty table then shifts up each entry that starts after the new
//  range before writing it. An insert into an empty table writes at once and
//  a table-full drop goes straight to FIN. A segment clipped to nothing goes
//  from CLIP to FIN. The walk over the interval memory reads one entry per
//  cycle through its registered read port.
//  Reset is synchronous on rst_n; it clears the sequence state, the ring
//  head and the interval count, the memory itself is not cleared. busy is
//  high from the accepting edge until the result strobe; results cannot be
//  held off.
// ============================================================================
module tcp_receive_reassembly #(
  parameter int unsigned RING_BYTES    = tcp_rr_pkg::RING_BYTES_DEF,
  parameter int unsigned TABLE_ENTRIES = tcp_rr_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  tcp_rr_pkg::seq_t   cfg_wdata,
  // command input
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  tcp_rr_pkg::seq_t   in_seg_seq,
  input  logic [15:0]        in_seg_len,
  input  logic [16:0]        in_read_count,
  // result
  output logic               out_valid,
  output tcp_rr_pkg::seq_t   out_next_expected,
  output logic [15:0]        out_write_pos,
  output logic [15:0]        out_write_skip,
  output logic [15:0]        out_write_len,
  output logic [15:0]        out_window,
  output logic [16:0]        out_readable,
  output logic [16:0]        out_bytes_read,
  output logic [15:0]        out_read_pos,
  output logic [4:0]         out_held_ranges,
  output logic               out_range_dropped
);

  import tcp_rr_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] TE_CNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [31:0]      RB32   = 32'(RING_BYTES);
  localparam logic [16:0]      RB17   = 17'(RING_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_WIN, ST_CLIP, ST_OFS, ST_WPOS, ST_WALK,
    ST_INS, ST_INS_EV, ST_INS_PUT, ST_READ, ST_READ2, ST_FIN, ST_OUT
  } state_t;

  // interval table
  span_t             mem_r [TABLE_ENTRIES];
  span_t             rd_data_r;
  logic [CNT_W-1:0]  rd_cnt;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [CNT_W-1:0]  wr_cnt;
  span_t             wr_data;

  // control and sequence state
  state_t            state_r, state_nxt;
  seq_t              rcv_r, rcv_nxt;
  seq_t              rs_r, rs_nxt;
  logic [15:0]       head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;

  // item working registers
  logic              func_r, func_nxt;
  seq_t              seq_r, seq_nxt;
  logic [15:0]       len_r, len_nxt;
  logic [16:0]       want_r, want_nxt;
  seq_t              s_r, s_nxt;
  seq_t              e_r, e_nxt;
  seq_t              used_r, used_nxt;
  seq_t              winend_r, winend_nxt;
  logic [16:0]       off_r, off_nxt;
  logic              mode_a_r, mode_a_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  w_r, w_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [15:0]       wpos_r, wpos_nxt;
  logic [15:0]       wskip_r, wskip_nxt;
  logic [15:0]       wlen_r, wlen_nxt;
  logic              dropped_r, dropped_nxt;
  logic [16:0]       nread_r, nread_nxt;
  logic [15:0]       rpos_r, rpos_nxt;

  // result registers
  seq_t              o_next_r, o_next_nxt;
  logic [15:0]       o_wpos_r, o_wpos_nxt;
  logic [15:0]       o_wskip_r, o_wskip_nxt;
  logic [15:0]       o_wlen_r, o_wlen_nxt;
  logic [15:0]       o_win_r, o_win_nxt;
  logic [16:0]       o_readable_r, o_readable_nxt;
  logic [16:0]       o_nread_r, o_nread_nxt;
  logic [15:0]       o_rpos_r, o_rpos_nxt;
  logic [4:0]        o_held_r, o_held_nxt;
  logic              o_dropped_r, o_dropped_nxt;

  assign rd_addr = rd_cnt[IDX_W-1:0];

  // --------------------------------------------------------------------------
  // Interval memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_cnt[IDX_W-1:0]] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    seq_t        e_clip;
    seq_t        diff;
    logic [15:0] win;
    logic [16:0] avail;
    logic [16:0] sum17;
    logic        keep;

    state_nxt      = state_r;
    rcv_nxt        = rcv_r;
    rs_nxt         = rs_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    func_nxt       = func_r;
    seq_nxt        = seq_r;
    len_nxt        = len_r;
    want_nxt       = want_r;
    s_nxt          = s_r;
    e_nxt          = e_r;
    used_nxt       = used_r;
    winend_nxt     = winend_r;
    off_nxt        = off_r;
    mode_a_nxt     = mode_a_r;
    i_nxt          = i_r;
    w_nxt          = w_r;
    j_nxt          = j_r;
    wpos_nxt       = wpos_r;
    wskip_nxt      = wskip_r;
    wlen_nxt       = wlen_r;
    dropped_nxt    = dropped_r;
    nread_nxt      = nread_r;
    rpos_nxt       = rpos_r;
    o_next_nxt     = o_next_r;
    o_wpos_nxt     = o_wpos_r;
    o_wskip_nxt    = o_wskip_r;
    o_wlen_nxt     = o_wlen_r;
    o_win_nxt      = o_win_r;
    o_readable_nxt = o_readable_r;
    o_nread_nxt    = o_nread_r;
    o_rpos_nxt     = o_rpos_r;
    o_held_nxt     = o_held_r;
    o_dropped_nxt  = o_dropped_r;
    rd_cnt         = '0;
    wr_en          = 1'b0;
    wr_cnt         = '0;
    wr_data        = rd_data_r;
    e_clip         = e_r;
    diff           = '0;
    win            = '0;
    avail          = '0;
    sum17          = '0;
    keep           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        // latch the command and clear both result halves
        if (start) begin
          func_nxt    = in_func;
          seq_nxt     = in_seg_seq;
          len_nxt     = in_seg_len;
          want_nxt    = in_read_count;
          wpos_nxt    = '0;
          wskip_nxt   = '0;
          wlen_nxt    = '0;
          dropped_nxt = 1'b0;
          nread_nxt   = '0;
          rpos_nxt    = '0;
          state_nxt   = ST_PREP;
        end
      end

      ST_PREP: begin
        // take ring occupancy; for a segment, trim the duplicate prefix and form the raw end
        used_nxt = rcv_r - rs_r;
        if (func_r) begin
          state_nxt = ST_READ;
        end else begin
          if (seq_before(seq_r, rcv_r)) begin
            s_nxt     = rcv_r;
            wskip_nxt = 16'(rcv_r - seq_r);
          end else begin
            s_nxt     = seq_r;
          end
          e_nxt     = seq_r + 32'(len_r);
          state_nxt = ST_WIN;
        end
      end

      ST_WIN: begin
        // right edge of the receive window
        if (used_r >= RB32) begin
          win = '0;
        end else begin
          diff = RB32 - used_r;
          win  = (diff > 32'(WIN_MAX)) ? WIN_MAX : diff[15:0];
        end
        winend_nxt = rcv_r + 32'(win);
        state_nxt  = ST_CLIP;
      end

      ST_CLIP: begin
        // clip to the window; drop empty ranges here
        e_clip = seq_before(winend_r, e_r) ? winend_r : e_r;
        if ((e_clip != s_r) && !seq_before(e_clip, s_r)) begin
          e_nxt     = e_clip;
          state_nxt = ST_OFS;
        end else begin
          wskip_nxt = '0;
          state_nxt = ST_FIN;
        end
      end

      ST_OFS: begin
        // in-order data advances the next expected sequence at once
        wlen_nxt   = 16'(e_r - s_r);
        off_nxt    = 17'(s_r - rs_r);
        mode_a_nxt = (s_r == rcv_r);
        if ((s_r == rcv_r) && seq_before(rcv_r, e_r)) begin
          rcv_nxt = e_r;
        end
        state_nxt = ST_WPOS;
      end

      ST_WPOS: begin
        sum17    = {1'b0, head_r} + off_r;
        wpos_nxt = 16'((sum17 >= RB17) ? (sum17 - RB17) : sum17);
        i_nxt    = '0;
        w_nxt    = '0;
        if (count_r == '0) begin
          state_nxt = mode_a_r ? ST_FIN : ST_INS;
        end else begin
          rd_cnt    = '0;
          state_nxt = ST_WALK;
        end
      end

      ST_WALK: begin
        // rd_data_r holds entry i; compact survivors down to slot w
        if (mode_a_r) begin
          keep = !((rd_data_r.lo == rcv_r) || seq_before(rd_data_r.lo, rcv_r));
          if (!keep && seq_before(rcv_r, rd_data_r.hi)) begin
            rcv_nxt = rd_data_r.hi;
          end
        end else begin
          keep = seq_before(e_r, rd_data_r.lo) || seq_before(rd_data_r.hi, s_r);
          if (!keep) begin
            if (seq_before(rd_data_r.lo, s_r)) begin
              s_nxt = rd_data_r.lo;
            end
            if (seq_before(e_r, rd_data_r.hi)) begin
              e_nxt = rd_data_r.hi;
            end
          end
        end
        if (keep) begin
          wr_en   = 1'b1;
          wr_cnt  = w_r;
          wr_data = rd_data_r;
          w_nxt   = w_r + CNT_W'(1);
        end
        i_nxt = i_r + CNT_W'(1);
        if ((i_r + CNT_W'(1)) == count_r) begin
          if (mode_a_r) begin
            count_nxt = w_nxt;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_INS;
          end
        end else begin
          rd_cnt = i_r + CNT_W'(1);
        end
      end

      ST_INS: begin
        if (w_r == TE_CNT) begin
          // table full: drop the merged range, absorbed entries stay gone
          dropped_nxt = 1'b1;
          count_nxt   = w_r;
          state_nxt   = ST_FIN;
        end else if (w_r == '0) begin
          wr_en     = 1'b1;
          wr_cnt    = '0;
          wr_data   = '{lo: s_r, hi: e_r};
          count_nxt = CNT_W'(1);
          state_nxt = ST_FIN;
        end else begin
          rd_cnt    = w_r - CNT_W'(1);
          j_nxt     = w_r;
          state_nxt = ST_INS_EV;
        end
      end

      ST_INS_EV: begin
        // rd_data_r holds entry j-1; shift it up while it starts after s
        if (seq_before(s_r, rd_data_r.lo)) begin
          wr_en   = 1'b1;
          wr_cnt  = j_r;
          wr_data = rd_data_r;
          if (j_r == CNT_W'(1)) begin
            j_nxt     = '0;
            state_nxt = ST_INS_PUT;
          end else begin
            rd_cnt = j_r - CNT_W'(2);
            j_nxt  = j_r - CNT_W'(1);
          end
        end else begin
          wr_en     = 1'b1;
          wr_cnt    = j_r;
          wr_data   = '{lo: s_r, hi: e_r};
          count_nxt = w_r + CNT_W'(1);
          state_nxt = ST_FIN;
        end
      end

      ST_INS_PUT: begin
        wr_en     = 1'b1;
        wr_cnt    = j_r;
        wr_data   = '{lo: s_r, hi: e_r};
        count_nxt = w_r + CNT_W'(1);
        state_nxt = ST_FIN;
      end

      ST_READ: begin
        avail     = (used_r > 32'(READ_SAT)) ? READ_SAT : used_r[16:0];
        nread_nxt = (want_r < avail) ? want_r : avail;
        rpos_nxt  = head_r;
        state_nxt = ST_READ2;
      end

      ST_READ2: begin
        // advance the ring head and the read sequence
        sum17     = {1'b0, head_r} + nread_r;
        head_nxt  = 16'((sum17 >= RB17) ? (sum17 - RB17) : sum17);
        rs_nxt    = rs_r + 32'(nread_r);
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        used_nxt  = rcv_r - rs_r;
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (used_r >= RB32) begin
          win = '0;
        end else begin
          diff = RB32 - used_r;
          win  = (diff > 32'(WIN_MAX)) ? WIN_MAX : diff[15:0];
        end
        o_next_nxt     = rcv_r;
        o_wpos_nxt     = wpos_r;
        o_wskip_nxt    = wskip_r;
        o_wlen_nxt     = wlen_r;
        o_win_nxt      = win;
        o_readable_nxt = (used_r > 32'(READ_SAT)) ? READ_SAT : used_r[16:0];
        o_nread_nxt    = nread_r;
        o_rpos_nxt     = rpos_r;
        o_held_nxt     = 5'(count_r);
        o_dropped_nxt  = dropped_r;
        out_valid_nxt  = 1'b1;
        state_nxt      = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // reload the sequence state and empty the table
    if (cfg_we) begin
      rcv_nxt   = cfg_wdata;
      rs_nxt    = cfg_wdata;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rcv_r       <= '0;
      rs_r        <= '0;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rcv_r       <= rcv_nxt;
      rs_r        <= rs_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    seq_r        <= seq_nxt;
    len_r        <= len_nxt;
    want_r       <= want_nxt;
    s_r          <= s_nxt;
    e_r          <= e_nxt;
    used_r       <= used_nxt;
    winend_r     <= winend_nxt;
    off_r        <= off_nxt;
    mode_a_r     <= mode_a_nxt;
    i_r          <= i_nxt;
    w_r          <= w_nxt;
    j_r          <= j_nxt;
    wpos_r       <= wpos_nxt;
    wskip_r      <= wskip_nxt;
    wlen_r       <= wlen_nxt;
    dropped_r    <= dropped_nxt;
    nread_r      <= nread_nxt;
    rpos_r       <= rpos_nxt;
    o_next_r     <= o_next_nxt;
    o_wpos_r     <= o_wpos_nxt;
    o_wskip_r    <= o_wskip_nxt;
    o_wlen_r     <= o_wlen_nxt;
    o_win_r      <= o_win_nxt;
    o_readable_r <= o_readable_nxt;
    o_nread_r    <= o_nread_nxt;
    o_rpos_r     <= o_rpos_nxt;
    o_held_r     <= o_held_nxt;
    o_dropped_r  <= o_dropped_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_next_expected = o_next_r;
  assign out_write_pos     = o_wpos_r;
  assign out_write_skip    = o_wskip_r;
  assign out_write_len     = o_wlen_r;
  assign out_window        = o_win_r;
  assign out_readable      = o_readable_r;
  assign out_bytes_read    = o_nread_r;
  assign out_read_pos      = o_rpos_r;
  assign out_held_ranges   = o_held_r;
  assign out_range_dropped = o_dropped_r;

endmodule
